// File: src/sbei_pkg.sv
// sbei_pkg: shared types and constants for the segment versus box edge test
// holds edge indexes, the per-edge check flags and the result beat width
// no dependencies
`default_nettype none

package sbei_pkg;

    // box edges, one check each
    localparam int NUM_EDGES   = 4;
    localparam int EDGE_BOTTOM = 0;
    localparam int EDGE_LEFT   = 1;
    localparam int EDGE_RIGHT  = 2;
    localparam int EDGE_TOP    = 3;

    // result beat holds hit in bit 0, padded to one byte
    localparam int OUT_TDATA_W = 8;

    // segment parameter checks for one edge
    typedef struct packed {
        logic t_ok;   // segment parameter within [0,1]
        logic u_ok;   // edge parameter within [0,1]
    } edge_flags_t;

    typedef logic [NUM_EDGES-1:0] edge_mask_t;

endpackage

`default_nettype wire

// File: src/sbei_edge_check.sv
// sbei_edge_check: inclusive [0,1] range tests of both edge parameters
// checks num/den within [0,1] by sign and magnitude, no division
// depends on sbei_pkg
`default_nettype none

module sbei_edge_check #(
    parameter int TW = 18,
    parameter int UW = 36
) (
    input  wire logic signed [TW-1:0] t_num,
    input  wire logic signed [TW-1:0] t_den,
    input  wire logic signed [UW-1:0] u_num,
    input  wire logic signed [UW-1:0] u_den,
    output sbei_pkg::edge_flags_t     flags
);

    logic t_pos;
    logic t_neg;
    logic u_pos;
    logic u_neg;

    // positive denominator: 0 <= num <= den
    // negative denominator: den <= num <= 0; zero denominator never passes
    always_comb
    begin
        t_pos = (t_den > $signed({TW{1'b0}})) && (t_num >= $signed({TW{1'b0}}))
                && (t_num <= t_den);
        t_neg = (t_den < $signed({TW{1'b0}})) && (t_num <= $signed({TW{1'b0}}))
                && (t_num >= t_den);
        u_pos = (u_den > $signed({UW{1'b0}})) && (u_num >= $signed({UW{1'b0}}))
                && (u_num <= u_den);
        u_neg = (u_den < $signed({UW{1'b0}})) && (u_num <= $signed({UW{1'b0}}))
                && (u_num >= u_den);
        flags.t_ok = t_pos || t_neg;
        flags.u_ok = u_pos || u_neg;
    end

endmodule

`default_nettype wire

// File: src/segment_box_edge_intersect.sv
// segment_box_edge_intersect: segment versus axis-aligned box edge crossing test
// four-stage pipeline: differences, products, cross terms, range checks
// depends on sbei_pkg and sbei_edge_check
//
// Usage: one query beat on the s_ group gives one result beat on the m_ group.
// s_tdata carries the segment start and end points, the box center and the box
// half sizes; m_tdata bit 0 is hit, set when the segment touches or crosses
// any of the four box edges (parallel edges and zero-length edges never hit).
// Each beat moves through the stage registers in order, and m_tvalid is the
// valid bit of the last stage. Throughput is one beat per cycle while m_tready
// is high; each stage holds one beat and the clock period is set by the six
// (COORD_BITS+2)-bit signed multipliers of the product stage.
// When the receiver holds m_tready low the pipeline keeps filling its empty
// stages and then drops s_tready; no beat is lost or repeated. s_tready
// follows m_tready in the same cycle once every stage is full.
// Reset clears all stage valid bits; nothing else is kept between queries.
`default_nettype none

module segment_box_edge_intersect #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // query beat
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // fields from bit 0: seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    // box_center_x, box_center_y (COORD_BITS each), box_half_x, box_half_y
    // (COORD_BITS-1 each), zero padding to whole bytes
    input  wire logic [((8*COORD_BITS-2+7)/8)*8-1:0] s_tdata,
    // result beat
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // fields from bit 0: hit, zero padding
    output logic [sbei_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    localparam int C  = COORD_BITS;
    localparam int HW = COORD_BITS - 1;
    localparam int DW = COORD_BITS + 2;
    localparam int PW = 2 * DW;

    // field offsets inside s_tdata
    localparam int OFS_AX = 0;
    localparam int OFS_AY = C;
    localparam int OFS_BX = 2 * C;
    localparam int OFS_BY = 3 * C;
    localparam int OFS_PX = 4 * C;
    localparam int OFS_PY = 5 * C;
    localparam int OFS_HX = 6 * C;
    localparam int OFS_HY = 6 * C + HW;

    // stage handshake
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    // stage 1 payload
    logic signed [DW-1:0] rx_reg, ry_reg, dx0_reg, dx1_reg, dy0_reg, dy1_reg;
    logic signed [DW-1:0] sx_reg, sy_reg;
    logic signed [DW-1:0] rx_next, ry_next, dx0_next, dx1_next, dy0_next, dy1_next;
    logic signed [DW-1:0] sx_next, sy_next;

    // stage 2 payload
    logic signed [PW-1:0] pxr_reg, pyr_reg;             // ry*Sx, rx*Sy
    logic signed [PW-1:0] dx0ry_reg, dx1ry_reg, dy0rx_reg, dy1rx_reg;
    logic signed [DW-1:0] rx2_reg, ry2_reg, dx0_2_reg, dx1_2_reg, dy0_2_reg, dy1_2_reg;

    // stage 3 payload
    logic signed [PW-1:0] k00_reg, nk00_reg, k10_reg, k11_reg, pxr3_reg, pyr3_reg;
    logic signed [PW-1:0] k00_next, k10_next, k11_next;
    logic signed [DW-1:0] rx3_reg, ry3_reg, dx0_3_reg, dx1_3_reg, dy0_3_reg, dy1_3_reg;

    // stage 4 result
    logic                 hit_reg;
    logic                 hit_next;
    sbei_pkg::edge_flags_t flags [sbei_pkg::NUM_EDGES];
    sbei_pkg::edge_mask_t  edge_hit;

    // each stage moves when it is empty or its successor moves
    assign adv4     = !v4_reg || m_tready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= s_tvalid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    // stage 1: segment direction, corner offsets and doubled half sizes
    always_comb
    begin
        logic signed [DW-1:0] ax, ay, bx, by, px, py, hx, hy;
        ax = DW'($signed(s_tdata[OFS_AX +: C]));
        ay = DW'($signed(s_tdata[OFS_AY +: C]));
        bx = DW'($signed(s_tdata[OFS_BX +: C]));
        by = DW'($signed(s_tdata[OFS_BY +: C]));
        px = DW'($signed(s_tdata[OFS_PX +: C]));
        py = DW'($signed(s_tdata[OFS_PY +: C]));
        hx = $signed({3'b000, s_tdata[OFS_HX +: HW]});
        hy = $signed({3'b000, s_tdata[OFS_HY +: HW]});
        rx_next  = bx - ax;
        ry_next  = by - ay;
        dx0_next = px - hx - ax;
        dx1_next = px + hx - ax;
        dy0_next = py - hy - ay;
        dy1_next = py + hy - ay;
        sx_next  = $signed({2'b00, s_tdata[OFS_HX +: HW], 1'b0});
        sy_next  = $signed({2'b00, s_tdata[OFS_HY +: HW], 1'b0});
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            dx0_reg <= dx0_next;
            dx1_reg <= dx1_next;
            dy0_reg <= dy0_next;
            dy1_reg <= dy1_next;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
        end
    end

    // stage 2: the six products
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            pxr_reg   <= PW'(ry_reg) * PW'(sx_reg);
            pyr_reg   <= PW'(rx_reg) * PW'(sy_reg);
            dx0ry_reg <= PW'(dx0_reg) * PW'(ry_reg);
            dx1ry_reg <= PW'(dx1_reg) * PW'(ry_reg);
            dy0rx_reg <= PW'(dy0_reg) * PW'(rx_reg);
            dy1rx_reg <= PW'(dy1_reg) * PW'(rx_reg);
            rx2_reg   <= rx_reg;
            ry2_reg   <= ry_reg;
            dx0_2_reg <= dx0_reg;
            dx1_2_reg <= dx1_reg;
            dy0_2_reg <= dy0_reg;
            dy1_2_reg <= dy1_reg;
        end
    end

    // stage 3: corner cross products against the segment direction
    assign k00_next = dx0ry_reg - dy0rx_reg;
    assign k10_next = dx1ry_reg - dy0rx_reg;
    assign k11_next = dx1ry_reg - dy1rx_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            k00_reg   <= k00_next;
            nk00_reg  <= -k00_next;
            k10_reg   <= k10_next;
            k11_reg   <= k11_next;
            pxr3_reg  <= pxr_reg;
            pyr3_reg  <= pyr_reg;
            rx3_reg   <= rx2_reg;
            ry3_reg   <= ry2_reg;
            dx0_3_reg <= dx0_2_reg;
            dx1_3_reg <= dx1_2_reg;
            dy0_3_reg <= dy0_2_reg;
            dy1_3_reg <= dy1_2_reg;
        end
    end

    // stage 4: range checks per edge, the box half size scales out of t
    sbei_edge_check #(.TW(DW), .UW(PW)) u_bottom (
        .t_num (dy0_3_reg),
        .t_den (ry3_reg),
        .u_num (nk00_reg),
        .u_den (pxr3_reg),
        .flags (flags[sbei_pkg::EDGE_BOTTOM])
    );

    sbei_edge_check #(.TW(DW), .UW(PW)) u_left (
        .t_num (dx0_3_reg),
        .t_den (rx3_reg),
        .u_num (k00_reg),
        .u_den (pyr3_reg),
        .flags (flags[sbei_pkg::EDGE_LEFT])
    );

    sbei_edge_check #(.TW(DW), .UW(PW)) u_right (
        .t_num (dx1_3_reg),
        .t_den (rx3_reg),
        .u_num (k10_reg),
        .u_den (pyr3_reg),
        .flags (flags[sbei_pkg::EDGE_RIGHT])
    );

    sbei_edge_check #(.TW(DW), .UW(PW)) u_top (
        .t_num (dy1_3_reg),
        .t_den (ry3_reg),
        .u_num (k11_reg),
        .u_den (pxr3_reg),
        .flags (flags[sbei_pkg::EDGE_TOP])
    );

    // any edge with both parameters in range
    always_comb
    begin
        for (int i = 0; i < sbei_pkg::NUM_EDGES; i++)
        begin
            edge_hit[i] = flags[i].t_ok && flags[i].u_ok;
        end
        hit_next = |edge_hit;
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
            hit_reg <= hit_next;
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {{(sbei_pkg::OUT_TDATA_W-1){1'b0}}, hit_reg};

endmodule

`default_nettype wire

// File: sim/segment_box_edge_intersect_checker.sv
// segment_box_edge_intersect_checker: watches the query and result channels of the
// segment versus box edge test, predicts each hit bit and compares it with the block
// depends on sbei_pkg for the edge indexes and the result beat width
`timescale 1ns / 100ps

module segment_box_edge_intersect_checker #(
    parameter int COORD_BITS = 16,
    parameter int QUERY_W    = ((8*COORD_BITS-2+7)/8)*8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    // fields from bit 0: seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    // box_center_x, box_center_y, box_half_x, box_half_y, zero padding
    input  wire logic [QUERY_W-1:0]           s_tdata,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    // fields from bit 0: hit, zero padding
    input  wire logic [sbei_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                                fail_count,
    output int                                pending,
    output int                                results_checked,
    output int                                hits_seen
);

    // hit bits still owed by the block, oldest first
    logic expected_hits[$];

    initial
    begin
        fail_count      = 0;
        pending         = 0;
        results_checked = 0;
        hits_seen       = 0;
    end

    // one edge against the segment, both parameters inclusive in [0,1]
    function automatic logic edge_crossed(longint ax, longint ay, longint rx, longint ry,
                                          longint cx, longint cy, longint dx, longint dy);
        longint sx, sy, qx, qy, den, tn, un;
        sx  = dx - cx;
        sy  = dy - cy;
        qx  = cx - ax;
        qy  = cy - ay;
        den = rx * sy - ry * sx;
        tn  = qx * sy - qy * sx;
        un  = qx * ry - qy * rx;
        // parallel, collinear or zero-length edge never counts
        if (den == 0)
            return 1'b0;
        if (den > 0)
            return tn >= 0 && tn <= den && un >= 0 && un <= den;
        return tn <= 0 && tn >= den && un <= 0 && un >= den;
    endfunction

    // hit bit for one query beat
    function automatic logic predict_hit(logic [QUERY_W-1:0] beat);
        longint ax, ay, bx, by, px, py, hx, hy, x0, x1, y0, y1;
        logic   any_hit;
        logic   crossed;
        ax = longint'($signed(beat[0*COORD_BITS +: COORD_BITS]));
        ay = longint'($signed(beat[1*COORD_BITS +: COORD_BITS]));
        bx = longint'($signed(beat[2*COORD_BITS +: COORD_BITS]));
        by = longint'($signed(beat[3*COORD_BITS +: COORD_BITS]));
        px = longint'($signed(beat[4*COORD_BITS +: COORD_BITS]));
        py = longint'($signed(beat[5*COORD_BITS +: COORD_BITS]));
        hx = longint'($unsigned(beat[6*COORD_BITS +: COORD_BITS-1]));
        hy = longint'($unsigned(beat[7*COORD_BITS-1 +: COORD_BITS-1]));
        x0 = px - hx;
        x1 = px + hx;
        y0 = py - hy;
        y1 = py + hy;
        any_hit = 1'b0;
        for (int e = 0; e < sbei_pkg::NUM_EDGES; e++)
        begin
            case (e)
                sbei_pkg::EDGE_BOTTOM:
                    crossed = edge_crossed(ax, ay, bx - ax, by - ay, x0, y0, x1, y0);
                sbei_pkg::EDGE_LEFT:
                    crossed = edge_crossed(ax, ay, bx - ax, by - ay, x0, y0, x0, y1);
                sbei_pkg::EDGE_RIGHT:
                    crossed = edge_crossed(ax, ay, bx - ax, by - ay, x1, y0, x1, y1);
                sbei_pkg::EDGE_TOP:
                    crossed = edge_crossed(ax, ay, bx - ax, by - ay, x1, y1, x0, y1);
                default:
                    crossed = 1'b0;
            endcase
            any_hit |= crossed;
        end
        return any_hit;
    endfunction

    // predict on accepted query beats, compare on accepted result beats
    always @(posedge clk)
    begin
        logic want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_hits.push_back(predict_hit(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none, got hit %0d",
                             $time, m_tdata[0]);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (m_tdata[0] !== want)
                    begin
                        $display("%0t: hit mismatch, expected %0d, got %0d",
                                 $time, want, m_tdata[0]);
                        fail_count <= fail_count + 1;
                    end
                    results_checked <= results_checked + 1;
                    if (want)
                        hits_seen <= hits_seen + 1;
                end
            end
            pending <= expected_hits.size();
        end
    end

endmodule

// File: sim/segment_box_edge_intersect_test.sv
// segment_box_edge_intersect_test: stimulus and verdict for the segment versus box
// edge test; directed corner cases, then random queries with idling and a long stall
// depends on sbei_pkg, segment_box_edge_intersect and segment_box_edge_intersect_checker
`timescale 1ns / 100ps

module segment_box_edge_intersect_test;

    localparam int COORD_BITS   = 16;
    localparam int QUERY_W      = ((8*COORD_BITS-2+7)/8)*8;
    localparam int NUM_RANDOM   = 1200;
    localparam int QUIET_FROM   = 1050;
    localparam int STALL_AT     = 400;
    localparam int STALL_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    // fields from bit 0: seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    // box_center_x, box_center_y, box_half_x, box_half_y, zero padding
    logic [QUERY_W-1:0]                s_tdata = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    // fields from bit 0: hit, zero padding
    logic [sbei_pkg::OUT_TDATA_W-1:0]  m_tdata;

    logic idle_enable = 1'b1;
    logic stall_request = 1'b0;
    logic stall_done = 1'b0;
    int   ready_hold = 0;
    int   cycle_count = 0;
    int   fail_count, pending, results_checked, hits_seen;

    segment_box_edge_intersect #(.COORD_BITS(COORD_BITS)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    segment_box_edge_intersect_checker #(.COORD_BITS(COORD_BITS)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .hits_seen       (hits_seen)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // result side: short random stalls, one long stall on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end
        else if (stall_request && !stall_done)
        begin
            ready_hold <= STALL_CYCLES - 1;
            stall_done <= 1'b1;
            m_tready   <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            ready_hold <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // field values are truncated to their widths
    function automatic logic [QUERY_W-1:0] pack_query(int sx, int sy, int ex, int ey,
                                                      int cx, int cy, int hx, int hy);
        return {{(QUERY_W-8*COORD_BITS+2){1'b0}},
                (COORD_BITS-1)'(hy), (COORD_BITS-1)'(hx),
                COORD_BITS'(cy), COORD_BITS'(cx), COORD_BITS'(ey), COORD_BITS'(ex),
                COORD_BITS'(sy), COORD_BITS'(sx)};
    endfunction

    function automatic int spread(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // random query, mostly segments placed around a small box
    function automatic logic [QUERY_W-1:0] random_query();
        int kind, cx, cy, hx, hy, sx, sy, ex, ey, reach;
        kind = $urandom_range(0, 9);
        cx = spread(30000);
        cy = spread(30000);
        hx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 300);
        hy = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 300);
        reach = (hx > hy ? hx : hy) + 200;
        sx = cx + spread(reach);
        sy = cy + spread(reach);
        ex = cx + spread(reach);
        ey = cy + spread(reach);
        case (kind)
            0, 1:
            begin
                // any bit pattern at all
                return {$urandom, $urandom, $urandom, $urandom};
            end
            7:
            begin
                // axis-aligned segment, often on an edge line
                if ($urandom_range(0, 1))
                begin
                    sy = $urandom_range(0, 1) ? cy + hy : sy;
                    ey = sy;
                end
                else
                begin
                    sx = $urandom_range(0, 1) ? cx - hx : sx;
                    ex = sx;
                end
            end
            8:
            begin
                // degenerate segment or flat box
                case ($urandom_range(0, 2))
                    0: begin ex = sx; ey = sy; end
                    1: hx = 0;
                    default: hy = 0;
                endcase
            end
            9:
            begin
                // an end point on a corner
                ex = $urandom_range(0, 1) ? cx + hx : cx - hx;
                ey = $urandom_range(0, 1) ? cy + hy : cy - hy;
            end
            default: ;
        endcase
        return pack_query(sx, sy, ex, ey, cx, cy, hx, hy);
    endfunction

    // one query beat, with an occasional idle burst before it
    task automatic send_query(logic [QUERY_W-1:0] beat);
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: crossings, touches, parallels and degenerate boxes
        send_query(pack_query(-100, 0, 100, 0, 0, 0, 50, 50));
        send_query(pack_query(100, 0, -100, 0, 0, 0, 50, 50));
        send_query(pack_query(-10, -10, 10, 10, 0, 0, 50, 50));
        send_query(pack_query(200, 200, 300, 300, 0, 0, 50, 50));
        send_query(pack_query(50, 0, 50, 0, 0, 0, 50, 50));
        send_query(pack_query(0, 100, 100, 0, 0, 0, 50, 50));
        send_query(pack_query(-100, 0, -50, 0, 0, 0, 50, 50));
        send_query(pack_query(0, 100, 0, 50, 0, 0, 50, 50));
        send_query(pack_query(-100, -50, 100, -50, 0, 0, 50, 50));
        send_query(pack_query(-100, 60, 100, 60, 0, 0, 50, 50));
        send_query(pack_query(-100, 0, 100, 0, 0, 0, 0, 50));
        send_query(pack_query(0, -100, 0, 100, 0, 0, 50, 0));
        send_query(pack_query(-100, -100, 100, 100, 0, 0, 0, 0));
        send_query(pack_query(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767));
        send_query(pack_query(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_query(pack_query(-32768, -32768, 32767, 32767, 0, 0, 32767, 32767));
        send_query(pack_query(32767, -32768, -32768, 32767, -32768, 32767, 32767, 0));
        send_query(pack_query(-32768, 32767, 32767, -32768, 32767, -32768, 0, 32767));
        send_query(pack_query(32767, 0, -32768, 0, 32767, 0, 32767, 32767));
        send_query(pack_query(16'h5555, 16'haaaa, 16'haaaa, 16'h5555,
                              16'h5555, 16'haaaa, 15'h2aaa, 15'h5555));
        send_query(pack_query(16'haaaa, 16'h5555, 16'h5555, 16'haaaa,
                              16'haaaa, 16'h5555, 15'h5555, 15'h2aaa));

        // random queries; long output stall part way, quiet tail at the end
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == STALL_AT)
                stall_request <= 1'b1;
            if (i == QUIET_FROM)
                idle_enable <= 1'b0;
            send_query(random_query());
        end
        s_tvalid <= 1'b0;

        // drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results (%0d hits) over directed edge cases and random queries,",
                 results_checked, hits_seen);
        $display("with random idling on both sides and one %0d-cycle output stall",
                 STALL_CYCLES);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
src/sbei_pkg.sv
src/sbei_edge_check.sv
src/segment_box_edge_intersect.sv
sim/segment_box_edge_intersect_checker.sv
sim/segment_box_edge_intersect_test.sv
